// ----- hw/rtl/hrr_pkg.sv -----
// ----------------------------------------------------------------------------
// Healing ratio relaxation package
// Shared constants, register indexes and helper types.
// ----------------------------------------------------------------------------
package hrr_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CAP    = 2'd2;
    localparam logic [1:0] CFG_LIMIT  = 2'd3;

    localparam logic [6:0]  WIDTH_RST  = 7'd64;
    localparam logic [6:0]  HEIGHT_RST = 7'd64;
    localparam logic [7:0]  CAP_RST    = 8'd100;
    localparam logic [31:0] LIMIT_RST  = 32'd42950;

    localparam logic [15:0] HEALED_MAX = 16'hFFFF;

    // Request sent to the divider.
    typedef struct packed {
        logic        go;
        logic [47:0] num;
        logic [34:0] den;
    } div_req_t;

endpackage

// ----- hw/rtl/hrr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hw/rtl/hrr_div.sv -----
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Unsigned 48-bit numerator by 35-bit denominator, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module hrr_div (
    input  logic             clk,
    input  logic             rst_n,
    input  hrr_pkg::div_req_t req,
    output logic             done,
    output logic [47:0]      quot
);

    logic [47:0] q_reg, q_next;
    logic [35:0] r_reg, r_next;
    logic [34:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[34:0], q_reg[47]};
        if (req.go)
        begin
            q_next    = req.num;
            r_next    = '0;
            d_next    = req.den;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- hw/rtl/healing_ratio_relaxation_unit.sv -----
// ----------------------------------------------------------------------------
// Healing ratio relaxation unit
// Stores per-channel target/clone ratios, relaxes them, returns healed pixels.
// ----------------------------------------------------------------------------
// A load keeps busy high while the three channel divisions share one serial
// divider in turn (issue, quotient bits, write). A read keeps busy high for the
// memory reads, three products and output register; its result follows in the
// next cycle. The load of the last pixel of the window runs relaxation: every
// pass walks each stored value through the ratio memory with one read port, an
// interior value through five reads (centre and four neighbors), a reciprocal
// multiply over PDIV and PDW for the divide by six, the square and the write, a
// border value through its centre read and the write, then a pass-end step. busy
// stays high throughout; results appear on result_valid for one cycle and
// cannot be held off. Configuration writes are taken only while the unit is
// idle and no request is offered.
module healing_ratio_relaxation_unit #(
    parameter int MAX_WIDTH  = hrr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hrr_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [15:0] target_l,
    input  logic [15:0] target_a,
    input  logic [15:0] target_b,
    input  logic [15:0] clone_l,
    input  logic [15:0] clone_a,
    input  logic [15:0] clone_b,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic [15:0] healed_l,
    output logic [15:0] healed_a,
    output logic [15:0] healed_b,
    output logic        last_pixel,
    output logic [7:0]  passes_run
);

    localparam int PIX   = MAX_WIDTH * MAX_HEIGHT;
    localparam int PW    = $clog2(PIX);
    localparam int RW    = $clog2(3 * PIX);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    // floor(x / 3) = (x * RECIP3) >> 35 for any x below 2^34.
    localparam logic [33:0] RECIP3 = 34'h2_AAAA_AAAB;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LDIV  = 5'd1;
    localparam logic [4:0] S_LWAIT = 5'd2;
    localparam logic [4:0] S_RRD   = 5'd3;
    localparam logic [4:0] S_RMUL  = 5'd4;
    localparam logic [4:0] S_ROUT  = 5'd5;
    localparam logic [4:0] S_PELEM = 5'd6;
    localparam logic [4:0] S_PRD   = 5'd7;
    localparam logic [4:0] S_PACC  = 5'd8;
    localparam logic [4:0] S_PDIV  = 5'd9;
    localparam logic [4:0] S_PDW   = 5'd10;
    localparam logic [4:0] S_PSQ   = 5'd11;
    localparam logic [4:0] S_PWR   = 5'd12;
    localparam logic [4:0] S_PEND  = 5'd13;
    localparam logic [4:0] S_RWAIT = 5'd14;

    logic [4:0]  st_reg, st_next;
    logic [6:0]  ww_reg, wh_reg;
    logic [7:0]  cap_reg;
    logic [31:0] lim_reg;

    logic [PW-1:0] lidx_reg, lidx_next, ridx_reg, ridx_next;
    logic          cur_reg, cur_next;
    logic [7:0]    pc_reg, pc_next;

    // Work registers
    logic [15:0]   t_reg [3];
    logic [15:0]   c_reg [3];
    logic [1:0]    k_reg, k_next;
    logic [2:0]    n_reg, n_next;
    logic [PW-1:0] pix_reg, pix_next;
    logic [HW-1:0] row_reg, row_next;
    logic [WW-1:0] col_reg, col_next;
    logic [34:0]   sum_reg, sum_next;
    logic [31:0]   ctr_reg, ctr_next;
    logic [31:0]   nv_reg, nv_next;
    logic [63:0]   sq_reg;
    logic [63:0]   err_reg, err_next;
    logic [7:0]    passes_reg, passes_next;
    logic [47:0]   prod_reg [3];
    logic [31:0]   rat_reg [3];
    logic          last_reg;
    logic [50:0]   plo_reg, plo_next;

    // Effective window
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [PW:0]   n_pix;
    logic [RW:0]   stride;

    always_comb
    begin
        if (ww_reg < 7'd2)
            w_eff = WW'(2);
        else if (int'(ww_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(ww_reg);
        if (wh_reg < 7'd2)
            h_eff = HW'(2);
        else if (int'(wh_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(wh_reg);
    end

    always_comb
    begin
        n_pix  = (PW+1)'(w_eff) * (PW+1)'(h_eff);
        stride = (RW+1)'(3 * w_eff);
    end

    // Memories
    logic            ra_we, rb_we, cs_we;
    logic [RW-1:0]   ra_addr, rb_addr;
    logic [31:0]     r_wdata, ra_rdata, rb_rdata, src_rdata;
    logic [PW-1:0]   cs_addr;
    logic [47:0]     cs_wdata, cs_rdata;

    hrr_ram #(.WIDTH(32), .DEPTH(3 * PIX)) u_ratio_a (
        .clk(clk), .we(ra_we), .addr(ra_addr), .wdata(r_wdata), .rdata(ra_rdata));
    hrr_ram #(.WIDTH(32), .DEPTH(3 * PIX)) u_ratio_b (
        .clk(clk), .we(rb_we), .addr(rb_addr), .wdata(r_wdata), .rdata(rb_rdata));
    hrr_ram #(.WIDTH(48), .DEPTH(PIX)) u_clone (
        .clk(clk), .we(cs_we), .addr(cs_addr), .wdata(cs_wdata), .rdata(cs_rdata));

    assign src_rdata = cur_reg ? rb_rdata : ra_rdata;

    hrr_pkg::div_req_t dreq;
    logic              ddone;
    logic [47:0]       dquot;

    hrr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dquot));

    logic accept;
    assign busy      = (st_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy && !start;

    // Address of the current element and neighbor selection
    logic [RW-1:0] elem_addr, rd_addr, wr_addr;
    logic          border;
    logic [15:0]   dsel;
    logic [31:0]   diff;
    logic [33:0]   half_sum;
    logic [50:0]   plo_w, phi_w;
    logic [67:0]   pfull_w;

    always_comb
    begin
        elem_addr = RW'(3 * pix_reg) + RW'(k_reg);
        border = (row_reg == '0) || (row_reg == h_eff - HW'(1)) ||
                 (col_reg == '0) || (col_reg == w_eff - WW'(1));
        unique case (n_reg)
            3'd0:    rd_addr = elem_addr;
            3'd1:    rd_addr = elem_addr - RW'(3);
            3'd2:    rd_addr = elem_addr + RW'(3);
            3'd3:    rd_addr = elem_addr - RW'(stride);
            default: rd_addr = elem_addr + RW'(stride);
        endcase
        wr_addr = RW'(3 * lidx_reg) + RW'(k_reg);
        dsel = (c_reg[k_reg] == 16'd0) ? 16'd1 : c_reg[k_reg];
        diff = (nv_reg >= ctr_reg) ? nv_reg - ctr_reg : ctr_reg - nv_reg;
        // The six-term sum divided by six is half the sum divided by three.
        half_sum = sum_reg[34:1];
        plo_w    = 51'(half_sum) * 51'(RECIP3[16:0]);
        phi_w    = 51'(half_sum) * 51'(RECIP3[33:17]);
        pfull_w  = {phi_w, 17'd0} + 68'(plo_reg);
    end

    always_comb
    begin
        st_next     = st_reg;
        lidx_next   = lidx_reg;
        ridx_next   = ridx_reg;
        cur_next    = cur_reg;
        pc_next     = pc_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        pix_next    = pix_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        sum_next    = sum_reg;
        ctr_next    = ctr_reg;
        nv_next     = nv_reg;
        err_next    = err_reg;
        passes_next = passes_reg;
        plo_next    = plo_reg;
        dreq        = '0;
        ra_we       = 1'b0;
        rb_we       = 1'b0;
        cs_we       = 1'b0;
        ra_addr     = rd_addr;
        rb_addr     = rd_addr;
        r_wdata     = dquot[31:0];
        cs_addr     = ridx_reg;
        cs_wdata    = {c_reg[2], c_reg[1], c_reg[0]};

        unique case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next = 2'd0;
                    if (!req_type)
                    begin
                        if ({1'b0, lidx_reg} >= n_pix)
                            lidx_next = '0;
                        st_next = S_LDIV;
                    end
                    else
                    begin
                        if ({1'b0, ridx_reg} >= n_pix)
                            ridx_next = '0;
                        st_next = S_RWAIT;
                    end
                end
            end
            S_LDIV:
            begin
                dreq.go  = 1'b1;
                dreq.num = {t_reg[k_reg], 32'd0} >> 16;
                dreq.den = 35'(dsel);
                st_next  = S_LWAIT;
            end
            S_LWAIT:
            begin
                ra_addr = wr_addr;
                rb_addr = wr_addr;
                if (ddone)
                begin
                    ra_we = !cur_reg;
                    rb_we = cur_reg;
                    if (k_reg == 2'd2)
                    begin
                        cs_addr = lidx_reg;
                        cs_we   = 1'b1;
                        if ({1'b0, lidx_reg} == n_pix - (PW+1)'(1))
                        begin
                            lidx_next   = '0;
                            ridx_next   = '0;
                            passes_next = '0;
                            err_next    = '0;
                            pix_next    = '0;
                            row_next    = '0;
                            col_next    = '0;
                            k_next      = 2'd0;
                            st_next     = S_PELEM;
                        end
                        else
                        begin
                            lidx_next = lidx_reg + PW'(1);
                            st_next   = S_IDLE;
                        end
                    end
                    else
                    begin
                        k_next  = k_reg + 2'd1;
                        st_next = S_LDIV;
                    end
                end
            end
            S_RWAIT:
            begin
                // Clone read and first ratio read issued; the other ratio reads follow one per cycle.
                cs_addr = ridx_reg;
                ra_addr = RW'(3 * ridx_reg);
                rb_addr = ra_addr;
                st_next = S_RRD;
            end
            S_RRD:
            begin
                ra_addr = RW'(3 * ridx_reg) + RW'(k_reg) + RW'(1);
                rb_addr = ra_addr;
                k_next  = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next  = 2'd0;
                    st_next = S_RMUL;
                end
            end
            S_RMUL:
            begin
                st_next = S_ROUT;
            end
            S_ROUT:
            begin
                ridx_next = ({1'b0, ridx_reg} == n_pix - (PW+1)'(1)) ? '0 :
                            ridx_reg + PW'(1);
                st_next = S_IDLE;
            end
            S_PELEM:
            begin
                // Read centre first.
                n_next   = 3'd0;
                sum_next = '0;
                st_next  = S_PRD;
            end
            S_PRD:
            begin
                // Issue read n; data arrives next cycle.
                st_next = S_PACC;
            end
            S_PACC:
            begin
                if (n_reg == 3'd0)
                begin
                    ctr_next = src_rdata;
                    sum_next = {2'b0, src_rdata, 1'b0};
                end
                else
                begin
                    sum_next = sum_reg + 35'(src_rdata);
                end
                if (border || n_reg == 3'd4)
                begin
                    st_next = S_PDIV;
                end
                else
                begin
                    n_next  = n_reg + 3'd1;
                    st_next = S_PRD;
                end
            end
            S_PDIV:
            begin
                if (border)
                begin
                    nv_next = ctr_reg;
                    st_next = S_PWR;
                end
                else
                begin
                    plo_next = plo_w;
                    st_next  = S_PDW;
                end
            end
            S_PDW:
            begin
                nv_next = pfull_w[66:35];
                st_next = S_PSQ;
            end
            S_PSQ:
            begin
                st_next = S_PWR;
            end
            S_PWR:
            begin
                r_wdata = nv_reg;
                ra_addr = elem_addr;
                rb_addr = elem_addr;
                ra_we   = cur_reg;
                rb_we   = !cur_reg;
                if (!border)
                    err_next = (err_reg > ~sq_reg) ? '1 : err_reg + sq_reg;
                if (k_reg != 2'd2)
                begin
                    k_next  = k_reg + 2'd1;
                    st_next = S_PELEM;
                end
                else
                begin
                    k_next = 2'd0;
                    if ({1'b0, pix_reg} == n_pix - (PW+1)'(1))
                    begin
                        st_next = S_PEND;
                    end
                    else
                    begin
                        pix_next = pix_reg + PW'(1);
                        if (col_reg == w_eff - WW'(1))
                        begin
                            col_next = '0;
                            row_next = row_reg + HW'(1);
                        end
                        else
                        begin
                            col_next = col_reg + WW'(1);
                        end
                        st_next = S_PELEM;
                    end
                end
            end
            S_PEND:
            begin
                cur_next    = !cur_reg;
                passes_next = passes_reg + 8'd1;
                pix_next    = '0;
                row_next    = '0;
                col_next    = '0;
                err_next    = '0;
                if (err_reg > {32'd0, lim_reg} && (passes_reg + 8'd1) < cap_reg)
                begin
                    st_next = S_PELEM;
                end
                else
                begin
                    pc_next = passes_reg + 8'd1;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            ww_reg  <= hrr_pkg::WIDTH_RST;
            wh_reg  <= hrr_pkg::HEIGHT_RST;
            cap_reg <= hrr_pkg::CAP_RST;
            lim_reg <= hrr_pkg::LIMIT_RST;
            lidx_reg <= '0;
            ridx_reg <= '0;
            cur_reg  <= 1'b0;
            pc_reg   <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            lidx_reg <= lidx_next;
            ridx_reg <= ridx_next;
            cur_reg  <= cur_next;
            pc_reg   <= pc_next;
            result_valid <= (st_reg == S_ROUT);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    hrr_pkg::CFG_WIDTH:  ww_reg  <= cfg_data[6:0];
                    hrr_pkg::CFG_HEIGHT: wh_reg  <= cfg_data[6:0];
                    hrr_pkg::CFG_CAP:    cap_reg <= cfg_data[7:0];
                    hrr_pkg::CFG_LIMIT:  lim_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    logic [47:0] prod_w [3];
    logic [15:0] heal_w [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_w[i] = 48'(rat_reg[i]) *
                        48'((c_reg[i] == 16'd0) ? 16'd1 : c_reg[i]);
            heal_w[i] = (prod_reg[i][47:32] != 16'd0) ? hrr_pkg::HEALED_MAX :
                        prod_reg[i][31:16];
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        n_reg      <= n_next;
        pix_reg    <= pix_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        sum_reg    <= sum_next;
        ctr_reg    <= ctr_next;
        nv_reg     <= nv_next;
        sq_reg     <= 64'(diff) * 64'(diff);
        err_reg    <= err_next;
        passes_reg <= passes_next;
        plo_reg    <= plo_next;
        if (accept)
        begin
            t_reg[0] <= target_l;
            t_reg[1] <= target_a;
            t_reg[2] <= target_b;
            c_reg[0] <= clone_l;
            c_reg[1] <= clone_a;
            c_reg[2] <= clone_b;
        end
        else if (st_reg == S_RRD && k_reg == 2'd0)
        begin
            c_reg[0] <= cs_rdata[15:0];
            c_reg[1] <= cs_rdata[31:16];
            c_reg[2] <= cs_rdata[47:32];
        end
        if (st_reg == S_RRD)
            rat_reg[k_reg] <= src_rdata;
        if (st_reg == S_RMUL)
        begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= prod_w[i];
        end
        if (st_reg == S_ROUT)
        begin
            healed_l   <= heal_w[0];
            healed_a   <= heal_w[1];
            healed_b   <= heal_w[2];
            last_reg   <= ({1'b0, ridx_reg} == n_pix - (PW+1)'(1));
            passes_run <= pc_reg;
        end
    end

    assign last_pixel = last_reg;

    ap_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(st_reg) == S_ROUT)
        else $error("result without read");
    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> busy)
        else $error("busy low while working");
    ap_buffer_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg != $past(cur_reg)) |-> $past(st_reg) == S_PEND)
        else $error("buffer flipped outside pass end");

endmodule

// ----- tb/healing_ratio_relaxation_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Healing ratio relaxation checker
// Watches the configuration, request and result channels of the unit, keeps
// its own copy of the ratio stores and relaxation state, and compares every
// healed pixel with the predicted one.
// ----------------------------------------------------------------------------
module healing_ratio_relaxation_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        req_type,
    input  logic [15:0] target_l,
    input  logic [15:0] target_a,
    input  logic [15:0] target_b,
    input  logic [15:0] clone_l,
    input  logic [15:0] clone_a,
    input  logic [15:0] clone_b,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        result_valid,
    input  logic [15:0] healed_l,
    input  logic [15:0] healed_a,
    input  logic [15:0] healed_b,
    input  logic        last_pixel,
    input  logic [7:0]  passes_run,
    output int          mismatches
);

    localparam int PIX_MAX = hrr_pkg::MAX_WIDTH_DEF * hrr_pkg::MAX_HEIGHT_DEF;

    typedef struct {
        logic [15:0] heal_l;
        logic [15:0] heal_a;
        logic [15:0] heal_b;
        logic        last;
        logic [7:0]  passes;
    } healed_pixel_t;

    logic [31:0] ratio_mem [2][3*PIX_MAX];
    logic [47:0] clone_mem [PIX_MAX];
    bit          ratio_written [2][PIX_MAX];
    bit          clone_written [PIX_MAX];
    int unsigned load_pos;
    int unsigned read_pos;
    bit          live_buf;
    logic [7:0]  pass_total;
    logic [6:0]  win_w_reg;
    logic [6:0]  win_h_reg;
    logic [7:0]  cap_reg;
    logic [31:0] limit_reg;
    healed_pixel_t healed_q[$];
    int unsigned windows_relaxed;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = win_w_reg;
        if (w < 2) w = 2;
        if (w > hrr_pkg::MAX_WIDTH_DEF) w = hrr_pkg::MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = win_h_reg;
        if (h < 2) h = 2;
        if (h > hrr_pkg::MAX_HEIGHT_DEF) h = hrr_pkg::MAX_HEIGHT_DEF;
        return h;
    endfunction

    function automatic int unsigned outstanding();
        return healed_q.size();
    endfunction

    function automatic int unsigned next_load_pos();
        return (load_pos >= eff_width() * eff_height()) ? 0 : load_pos;
    endfunction

    // A read is only legal when the pixel it lands on has been written.
    function automatic bit can_read();
        int unsigned idx;
        idx = (read_pos >= eff_width() * eff_height()) ? 0 : read_pos;
        return clone_written[idx] && ratio_written[live_buf][idx];
    endfunction

    function automatic void relax_window(int unsigned w, int unsigned h);
        int unsigned passes;
        int unsigned stride;
        int unsigned i;
        logic [63:0] err;
        logic [63:0] sum;
        logic [63:0] diff;
        logic [63:0] sq;
        logic [31:0] nv;
        bit          src;
        passes = 0;
        stride = 3 * w;
        do
        begin
            err = 0;
            src = live_buf;
            for (int unsigned r = 0; r < h; r++)
            begin
                for (int unsigned c = 0; c < w; c++)
                begin
                    for (int unsigned k = 0; k < 3; k++)
                    begin
                        i = r * stride + c * 3 + k;
                        if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
                        begin
                            ratio_mem[!src][i] = ratio_mem[src][i];
                        end
                        else
                        begin
                            sum = 64'(ratio_mem[src][i-3]) + 64'(ratio_mem[src][i+3])
                                + 64'(ratio_mem[src][i-stride])
                                + 64'(ratio_mem[src][i+stride])
                                + 2 * 64'(ratio_mem[src][i]);
                            nv = 32'(sum / 6);
                            diff = (nv >= ratio_mem[src][i]) ? 64'(nv - ratio_mem[src][i])
                                                              : 64'(ratio_mem[src][i] - nv);
                            sq = diff * diff;
                            ratio_mem[!src][i] = nv;
                            err = (err > ~64'd0 - sq) ? ~64'd0 : err + sq;
                        end
                    end
                end
            end
            for (int unsigned p = 0; p < w * h; p++)
                ratio_written[!src][p] = 1'b1;
            live_buf = !src;
            passes++;
        end
        while (err > 64'(limit_reg) && passes < cap_reg);
        pass_total = passes[7:0];
        windows_relaxed++;
    endfunction

    function automatic logic [31:0] ratio_of(logic [15:0] t, logic [15:0] cl);
        logic [47:0] num;
        num = {t, 16'd0};
        return 32'(num / ((cl == 0) ? 48'd1 : 48'(cl)));
    endfunction

    function automatic logic [15:0] heal_of(logic [31:0] ratio, logic [15:0] cl);
        logic [63:0] v;
        v = (64'(ratio) * ((cl == 0) ? 64'd1 : 64'(cl))) >> 16;
        return (v > 64'(hrr_pkg::HEALED_MAX)) ? hrr_pkg::HEALED_MAX : v[15:0];
    endfunction

    task automatic process_request();
        int unsigned n;
        healed_pixel_t px;
        logic [47:0] cl;
        n = eff_width() * eff_height();
        if (req_type == 1'b0)
        begin
            if (load_pos >= n) load_pos = 0;
            ratio_mem[live_buf][load_pos*3]   = ratio_of(target_l, clone_l);
            ratio_mem[live_buf][load_pos*3+1] = ratio_of(target_a, clone_a);
            ratio_mem[live_buf][load_pos*3+2] = ratio_of(target_b, clone_b);
            ratio_written[live_buf][load_pos] = 1'b1;
            clone_mem[load_pos] = {clone_b, clone_a, clone_l};
            clone_written[load_pos] = 1'b1;
            if (load_pos == n - 1)
            begin
                relax_window(eff_width(), eff_height());
                load_pos = 0;
                read_pos = 0;
            end
            else
            begin
                load_pos++;
            end
        end
        else
        begin
            if (read_pos >= n) read_pos = 0;
            cl = clone_mem[read_pos];
            px.heal_l = heal_of(ratio_mem[live_buf][read_pos*3],   cl[15:0]);
            px.heal_a = heal_of(ratio_mem[live_buf][read_pos*3+1], cl[31:16]);
            px.heal_b = heal_of(ratio_mem[live_buf][read_pos*3+2], cl[47:32]);
            px.last   = (read_pos == n - 1);
            px.passes = pass_total;
            healed_q.push_back(px);
            read_pos = (read_pos == n - 1) ? 0 : read_pos + 1;
        end
    endtask

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        healed_pixel_t px;
        if (!rst_n)
        begin
            load_pos   <= 0;
            read_pos   <= 0;
            live_buf   <= 1'b0;
            pass_total <= '0;
            win_w_reg  <= hrr_pkg::WIDTH_RST;
            win_h_reg  <= hrr_pkg::HEIGHT_RST;
            cap_reg    <= hrr_pkg::CAP_RST;
            limit_reg  <= hrr_pkg::LIMIT_RST;
            mismatches <= 0;
            windows_relaxed <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (healed_q.size() == 0)
                begin
                    $error("healed pixel with no request waiting");
                    mismatches++;
                end
                else
                begin
                    px = healed_q.pop_front();
                    compare_field("healed_l", px.heal_l, healed_l);
                    compare_field("healed_a", px.heal_a, healed_a);
                    compare_field("healed_b", px.heal_b, healed_b);
                    compare_field("last_pixel", 16'(px.last), 16'(last_pixel));
                    compare_field("passes_run", 16'(px.passes), 16'(passes_run));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hrr_pkg::CFG_WIDTH:  win_w_reg = cfg_data[6:0];
                    hrr_pkg::CFG_HEIGHT: win_h_reg = cfg_data[6:0];
                    hrr_pkg::CFG_CAP:    cap_reg   = cfg_data[7:0];
                    hrr_pkg::CFG_LIMIT:  limit_reg = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                process_request();
        end
    end

endmodule

// ----- tb/healing_ratio_relaxation_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Healing ratio relaxation testbench
// Drives load and read requests through a series of window settings, with
// and without gaps between requests; the checker predicts every healed pixel.
// ----------------------------------------------------------------------------
module healing_ratio_relaxation_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [15:0] target_l;
    logic [15:0] target_a;
    logic [15:0] target_b;
    logic [15:0] clone_l;
    logic [15:0] clone_a;
    logic [15:0] clone_b;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        result_valid;
    logic [15:0] healed_l;
    logic [15:0] healed_a;
    logic [15:0] healed_b;
    logic        last_pixel;
    logic [7:0]  passes_run;
    int          mismatches;
    int unsigned loads_sent;
    int unsigned reads_sent;

    healing_ratio_relaxation_unit dut (.*);
    healing_ratio_relaxation_unit_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("healing_ratio_relaxation_unit test failed");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (chk.outstanding() != 0 || busy) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Picks a channel value: extremes often, otherwise anything.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(bit is_read);
        req_type <= is_read;
        target_l <= pick_value();
        target_a <= pick_value();
        target_b <= pick_value();
        clone_l  <= pick_value();
        clone_a  <= pick_value();
        clone_b  <= pick_value();
        start    <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        if (is_read) reads_sent++;
        else loads_sent++;
    endtask

    // One setting of the registers, then a mix of loads and reads; the last
    // window is always completed so the next setting starts from pixel zero.
    task automatic run_phase(logic [6:0] w, logic [6:0] h, logic [7:0] cap,
                             logic [31:0] lim, int unsigned count, int unsigned idle_pct);
        int unsigned sent;
        bit          is_read;
        wait_idle();
        write_reg(hrr_pkg::CFG_WIDTH, 32'(w));
        write_reg(hrr_pkg::CFG_HEIGHT, 32'(h));
        write_reg(hrr_pkg::CFG_CAP, 32'(cap));
        write_reg(hrr_pkg::CFG_LIMIT, lim);
        sent = 0;
        forever
        begin
            @(posedge clk);
            if (sent >= count && chk.next_load_pos() == 0) break;
            if ($urandom_range(99) < idle_pct)
                repeat ($urandom_range(1, 6)) @(posedge clk);
            is_read = (sent < count) && ($urandom_range(99) < 45) && chk.can_read();
            send_request(is_read);
            sent++;
        end
    endtask

    initial
    begin
        int unsigned idle_pct;
        start     = 1'b0;
        req_type  = 1'b0;
        target_l  = '0;
        target_a  = '0;
        target_b  = '0;
        clone_l   = '0;
        clone_a   = '0;
        clone_b   = '0;
        cfg_valid = 1'b0;
        cfg_index = hrr_pkg::CFG_WIDTH;
        cfg_data  = '0;
        loads_sent = 0;
        reads_sent = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed settings: smallest window, out-of-range registers,
        // longest pass cap, widest and tallest windows.
        run_phase(7'd2, 7'd2, 8'd1, 32'd0, 12, 0);
        run_phase(7'd0, 7'd1, 8'd0, 32'hFFFF_FFFF, 8, 0);
        run_phase(7'd3, 7'd3, 8'd255, 32'd0, 20, 0);
        run_phase(7'd127, 7'd3, 8'd2, 32'd42950, 10, 8);
        run_phase(7'd2, 7'd127, 8'd2, 32'd1, 10, 8);

        for (int ph = 0; ph < 18; ph++)
        begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 62;
                default: idle_pct = 8;
            endcase
            run_phase(7'($urandom_range(2, 6)), 7'($urandom_range(2, 6)),
                      8'($urandom_range(1, 12)),
                      ($urandom_range(2) == 0) ? 32'($urandom) : 32'($urandom_range(0, 50000)),
                      80, idle_pct);
        end

        wait_idle();
        repeat (200) @(posedge clk);
        $display("Covered %0d loads and %0d reads over %0d relaxed windows.",
                 loads_sent, reads_sent, chk.windows_relaxed);
        if (mismatches == 0 && chk.outstanding() == 0)
            $display("healing_ratio_relaxation_unit test passed");
        else
            $display("healing_ratio_relaxation_unit test failed");
        $finish;
    end

endmodule
